// ===== rtl/mwl_pkg.sv =====
// shared types, constants and the sine quarter-wave table for the lfo
// depends on nothing; imported by mwl_wave and multi_waveform_lfo
package mwl_pkg;

  // fixed-point format of phase and wave
  localparam int FRAC_BITS        = 16;
  localparam int SINE_TABLE_DEPTH = 256;

  // field widths
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 24;
  localparam int SEL_W   = 3;
  localparam int PW_W    = 17;
  localparam int IDX_W   = 3;
  localparam int LFO_W   = 26;
  localparam int WAVE_W  = FRAC_BITS + 1;
  localparam int PHASE_W = CFG_W + FRAC_BITS;
  localparam int PROD_W  = WAVE_W + 1 + CFG_W;
  localparam int ROM_A_W = $clog2(SINE_TABLE_DEPTH + 1);

  // noise multiplier: round(0.9898 * one)
  localparam longint NOISE_K_L = (64'd9898 * (64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam logic [FRAC_BITS-1:0] NOISE_K = FRAC_BITS'(NOISE_K_L);

  // waveform codes
  typedef enum logic [SEL_W-1:0] {
    WAVE_SINE     = 3'd0,
    WAVE_TRIANGLE = 3'd1,
    WAVE_SAW      = 3'd2,
    WAVE_SQUARE   = 3'd3,
    WAVE_NOISE    = 3'd4
  } wave_sel_t;

  // register indexes on the config port
  typedef enum logic [IDX_W-1:0] {
    REG_WAVE_SEL     = 3'd0,
    REG_FREQUENCY    = 3'd1,
    REG_PHASE_OFFSET = 3'd2,
    REG_PULSE_WIDTH  = 3'd3,
    REG_AMPLITUDE    = 3'd4,
    REG_LEVEL_OFFSET = 3'd5
  } cfg_reg_t;

  // settings the waveform stage needs
  typedef struct packed {
    logic [SEL_W-1:0] sel;
    logic [PW_W-1:0]  pulse_width;
  } wave_cfg_t;

  typedef logic [FRAC_BITS-1:0] sine_rom_t [0:SINE_TABLE_DEPTH];

  // signed quotient rounded toward zero, by shift and subtract; used at elaboration only
  function automatic longint div_trunc(input longint num, input longint den);
    logic [63:0] n_mag;
    logic [63:0] d_mag;
    logic [63:0] q;
    logic [64:0] r;
    n_mag = (num < 0) ? 64'(-num) : 64'(num);
    d_mag = (den < 0) ? 64'(-den) : 64'(den);
    q     = '0;
    r     = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n_mag[b]};
      if (r >= {1'b0, d_mag}) begin
        r    = r - {1'b0, d_mag};
        q[b] = 1'b1;
      end
    end
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  // quarter-wave table, entry k = half * sin(pi/2 * k / depth), rounded half up;
  // sine evaluated in q2.30 by an eleven-term taylor series
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    longint    q30;
    longint    pi_q30;
    longint    x;
    longint    term;
    longint    sum;
    longint    half;
    q30    = 64'sd1 << 30;
    pi_q30 = 64'sd3373259426;
    half   = 64'sd1 << (FRAC_BITS - 1);
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = div_trunc(pi_q30 * k, 2 * SINE_TABLE_DEPTH);
      term = x;
      sum  = x;
      for (int n = 1; n <= 10; n++) begin
        term = div_trunc(term * x, q30);
        term = div_trunc(term * x, q30);
        term = div_trunc(-term, (2 * n) * (2 * n + 1));
        sum  = sum + term;
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > q30) begin
        sum = q30;
      end
      rom[k] = FRAC_BITS'((sum * half + (64'sd1 << 29)) >>> 30);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== rtl/mwl_wave.sv =====
// waveform stage: turns a phase fraction and cycle count into a q1.16 wave
// depends on mwl_pkg (widths, sine table, waveform codes)
module mwl_wave
  import mwl_pkg::*;
(
  input  logic                 clk,
  input  logic                 load,
  input  wave_cfg_t            cfg,
  input  logic [FRAC_BITS-1:0] frac,
  input  logic [FRAC_BITS-1:0] cyc,
  output logic [WAVE_W-1:0]    wave
);

  localparam int REM_W  = FRAC_BITS - 2;
  localparam int MUL_W  = REM_W + ROM_A_W;
  localparam int CMP_W  = (WAVE_W > PW_W) ? WAVE_W : PW_W;
  localparam logic [WAVE_W-1:0] ONE_Q  = WAVE_W'(1) << FRAC_BITS;
  localparam logic [WAVE_W-1:0] HALF_Q = WAVE_W'(1) << (FRAC_BITS - 1);
  localparam logic [ROM_A_W-1:0] DEPTH = ROM_A_W'(SINE_TABLE_DEPTH);

  logic [1:0]             quad;
  logic [REM_W-1:0]       rem;
  logic [MUL_W-1:0]       idx_prod;
  logic [ROM_A_W-1:0]     idx;
  logic [ROM_A_W-1:0]     rom_addr;
  logic [WAVE_W-1:0]      sine_s;
  logic [WAVE_W-1:0]      sine_w;
  logic [WAVE_W-1:0]      two_f;
  logic [WAVE_W-1:0]      tri_w;
  logic [2*FRAC_BITS-1:0] noise_prod;
  logic [WAVE_W-1:0]      wave_next;

  // sine: quadrant from the top two bits, table index from the rest
  always_comb begin
    quad     = frac[FRAC_BITS-1 -: 2];
    rem      = frac[REM_W-1:0];
    idx_prod = MUL_W'(rem) * MUL_W'(SINE_TABLE_DEPTH);
    idx      = idx_prod[MUL_W-1 -: ROM_A_W];
    rom_addr = quad[0] ? (DEPTH - idx) : idx;
    sine_s   = WAVE_W'(SINE_ROM[rom_addr]);
    sine_w   = quad[1] ? (HALF_Q - sine_s) : (HALF_Q + sine_s);
  end

  // triangle and noise
  always_comb begin
    two_f      = {frac, 1'b0};
    tri_w      = (two_f >= ONE_Q) ? (two_f - ONE_Q) : (ONE_Q - two_f);
    noise_prod = (2*FRAC_BITS)'(cyc) * (2*FRAC_BITS)'(NOISE_K);
  end

  // waveform select; unused codes fall to noise
  always_comb begin
    case (cfg.sel)
      WAVE_SINE:     wave_next = sine_w;
      WAVE_TRIANGLE: wave_next = tri_w;
      WAVE_SAW:      wave_next = WAVE_W'(frac);
      WAVE_SQUARE:   wave_next = (CMP_W'(frac) < CMP_W'(cfg.pulse_width)) ? ONE_Q : '0;
      default:       wave_next = WAVE_W'(noise_prod[FRAC_BITS-1:0]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      wave <= wave_next;
    end
  end

endmodule

// ===== rtl/multi_waveform_lfo.sv =====
// multi_waveform_lfo: five-waveform low-frequency oscillator, five-stage pipeline
// depends on mwl_pkg and mwl_wave
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid, in_ready, sample_time[31:0]    | into block
//   out     | out_valid, out_ready, lfo_value[25:0]    | out of block
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | into block
//
// one beat per clock sustained while out_ready is high; a beat passes five registered stages
// (time multiply, phase add, waveform, gain multiply, offset add) on its way out.
// rst clears every stage valid bit and loads the register reset values.
// with out_ready low the last stage holds and empty stages ahead still fill,
// so in_ready drops only once all five stages hold a beat. cfg_ready is always high.
module multi_waveform_lfo
  import mwl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [TIME_W-1:0]       sample_time,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [LFO_W-1:0] lfo_value,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  localparam int TP_W = TIME_W + CFG_W;
  localparam int SC_W = PROD_W - FRAC_BITS;

  // config registers
  logic [SEL_W-1:0]        waveform_select;
  logic [CFG_W-1:0]        frequency_hz;
  logic [CFG_W-1:0]        phase_offset;
  logic [PW_W-1:0]         pulse_width;
  logic signed [CFG_W-1:0] amplitude;
  logic signed [CFG_W-1:0] level_offset;
  wave_cfg_t               wave_cfg;

  // stage registers and enables
  logic                       s1_valid, s2_valid, s3_valid, s4_valid;
  logic                       en1, en2, en3, en4, en5;
  logic [PHASE_W-1:0]         s1_phase;
  logic [FRAC_BITS-1:0]       s2_frac;
  logic [FRAC_BITS-1:0]       s2_cyc;
  logic [WAVE_W-1:0]          s3_wave;
  logic signed [PROD_W-1:0]   s4_prod;
  logic [TP_W-1:0]            time_prod;
  logic [2*FRAC_BITS-1:0]     phase_sum;
  logic signed [SC_W-1:0]     scaled;
  logic signed [LFO_W-1:0]    lfo_value_next;

  assign cfg_ready = 1'b1;

  // register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      waveform_select <= SEL_W'(WAVE_SINE);
      frequency_hz    <= CFG_W'(65536);
      phase_offset    <= '0;
      pulse_width     <= PW_W'(32768);
      amplitude       <= CFG_W'(65536);
      level_offset    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WAVE_SEL:     waveform_select <= cfg_data[SEL_W-1:0];
        REG_FREQUENCY:    frequency_hz    <= cfg_data;
        REG_PHASE_OFFSET: phase_offset    <= cfg_data;
        REG_PULSE_WIDTH:  pulse_width     <= cfg_data[PW_W-1:0];
        REG_AMPLITUDE:    amplitude       <= cfg_data;
        REG_LEVEL_OFFSET: level_offset    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign wave_cfg.sel         = waveform_select;
  assign wave_cfg.pulse_width = pulse_width;

  // per-stage advance: a stage moves when empty or when the next one moves
  assign en5      = !out_valid || out_ready;
  assign en4      = !s4_valid || en5;
  assign en3      = !s3_valid || en4;
  assign en2      = !s2_valid || en3;
  assign en1      = !s1_valid || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) s1_valid  <= in_valid;
      if (en2) s2_valid  <= s1_valid;
      if (en3) s3_valid  <= s2_valid;
      if (en4) s4_valid  <= s3_valid;
      if (en5) out_valid <= s4_valid;
    end
  end

  // stage 1: time times frequency, keep FRAC_BITS fraction bits
  assign time_prod = TP_W'(sample_time) * TP_W'(frequency_hz);

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_phase <= time_prod[TP_W-1 -: PHASE_W];
    end
  end

  // stage 2: add phase offset, split fraction and low cycle bits
  assign phase_sum = s1_phase[2*FRAC_BITS-1:0] + (2*FRAC_BITS)'(phase_offset);

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_frac <= phase_sum[FRAC_BITS-1:0];
      s2_cyc  <= phase_sum[2*FRAC_BITS-1:FRAC_BITS];
    end
  end

  // stage 3: waveform
  mwl_wave u_wave (
    .clk  (clk),
    .load (en3),
    .cfg  (wave_cfg),
    .frac (s2_frac),
    .cyc  (s2_cyc),
    .wave (s3_wave)
  );

  // stage 4: gain
  always_ff @(posedge clk) begin
    if (en4) begin
      s4_prod <= signed'(PROD_W'({1'b0, s3_wave})) * PROD_W'(amplitude);
    end
  end

  // stage 5: floor to FRAC_BITS fraction bits, add level offset
  assign scaled         = s4_prod[PROD_W-1:FRAC_BITS];
  assign lfo_value_next = LFO_W'(scaled) + LFO_W'(level_offset);

  always_ff @(posedge clk) begin
    if (en5) begin
      lfo_value <= lfo_value_next;
    end
  end

endmodule
